FILE: rtl/dlts_pkg.sv
// ----------------------------------------------------------------------------
// dlts_pkg: shared types and constants for the delta list task scheduler
// Operation and status codes, default sizes, sequencer state encoding.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MaxTasksDef    = 16;
  localparam int TickWidthDef   = 16;
  localparam int IdWidthDef     = 16;
  localparam int HandleWidthDef = 8;

  // operation codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_DELETE   = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NOTDUE   = 2'd3;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIND   = 7'b0000010,  // walk entries looking for id or insert slot
    S_REMOVE = 7'b0000100,  // merge delay and shift entries up
    S_SHIFT  = 7'b0001000,  // shift entries down to open a slot
    S_PLACE  = 7'b0010000,  // write the new entry
    S_HEAD   = 7'b0100000,  // tick or dispatch on the head entry
    S_OUT    = 7'b1000000   // hold result beat
  } state_t;

endpackage

FILE: rtl/dlts_table.sv
// ----------------------------------------------------------------------------
// dlts_table: task table storage
// One entry read and at most one entry written per cycle; valid bits in flops.
// ----------------------------------------------------------------------------
module dlts_table #(
  parameter int MAX_TASKS    = dlts_pkg::MaxTasksDef,
  parameter int TICK_WIDTH   = dlts_pkg::TickWidthDef,
  parameter int ID_WIDTH     = dlts_pkg::IdWidthDef,
  parameter int HANDLE_WIDTH = dlts_pkg::HandleWidthDef,
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [AW-1:0]           rd_addr,
  output logic                    rd_valid,
  output logic [HANDLE_WIDTH-1:0] rd_handle,
  output logic [TICK_WIDTH-1:0]   rd_delay,
  output logic [TICK_WIDTH-1:0]   rd_period,
  output logic [ID_WIDTH-1:0]     rd_id,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic                    wr_valid,
  input  logic [HANDLE_WIDTH-1:0] wr_handle,
  input  logic [TICK_WIDTH-1:0]   wr_delay,
  input  logic [TICK_WIDTH-1:0]   wr_period,
  input  logic [ID_WIDTH-1:0]     wr_id
);

  logic [MAX_TASKS-1:0]    vld;
  logic [HANDLE_WIDTH-1:0] mem_handle [MAX_TASKS];
  logic [TICK_WIDTH-1:0]   mem_delay  [MAX_TASKS];
  logic [TICK_WIDTH-1:0]   mem_period [MAX_TASKS];
  logic [ID_WIDTH-1:0]     mem_id     [MAX_TASKS];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= wr_valid;
    end
  end

  // payload store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_handle[wr_addr] <= wr_handle;
      mem_delay[wr_addr]  <= wr_delay;
      mem_period[wr_addr] <= wr_period;
      mem_id[wr_addr]     <= wr_id;
    end
    rd_handle <= mem_handle[rd_addr];
    rd_delay  <= mem_delay[rd_addr];
    rd_period <= mem_period[rd_addr];
    rd_id     <= mem_id[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= vld[rd_addr] && !(wr_en && wr_addr == rd_addr);
    end
  end

endmodule

FILE: rtl/delta_list_task_scheduler.sv
// ----------------------------------------------------------------------------
// delta_list_task_scheduler: cooperative scheduler on a delta list
// Tasks kept sorted by due time, each delay relative to its predecessor.
//
//   channel | direction | beat contents
//   in      | sink      | mode, task_handle, start_delay, repeat_period, target_id
//   out     | source    | status, assigned_id, ran_handle, ran_id
//
// One item at a time; in_ready is high only in idle with no result pending.
// The table has one read and one write port and one shared add/compare unit;
// every table step (scan, shift, merge) reads an entry, then acts on the data.
// Dispatch of a periodic task: remove then insert.
// Synchronous reset clears valid bits, last id and control; no clearing pass.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler #(
  parameter int MAX_TASKS    = dlts_pkg::MaxTasksDef,
  parameter int TICK_WIDTH   = dlts_pkg::TickWidthDef,
  parameter int ID_WIDTH     = dlts_pkg::IdWidthDef,
  parameter int HANDLE_WIDTH = dlts_pkg::HandleWidthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  task_handle,
  input  logic [15:0] start_delay,
  input  logic [15:0] repeat_period,
  input  logic [15:0] target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] assigned_id,
  output logic [7:0]  ran_handle,
  output logic [15:0] ran_id
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST = CW'(MAX_TASKS - 1);
  localparam logic [TICK_WIDTH-1:0] TMAX = '1;

  dlts_pkg::state_t state;

  // table port signals
  logic [AW-1:0]           rd_addr;
  logic                    rd_valid;
  logic [HANDLE_WIDTH-1:0] rd_handle;
  logic [TICK_WIDTH-1:0]   rd_delay, rd_period;
  logic [ID_WIDTH-1:0]     rd_id;
  logic                    wr_en, wr_valid;
  logic [AW-1:0]           wr_addr;
  logic [HANDLE_WIDTH-1:0] wr_handle;
  logic [TICK_WIDTH-1:0]   wr_delay, wr_period;
  logic [ID_WIDTH-1:0]     wr_id;

  // sequencer registers
  logic [1:0]              op;
  logic [CW-1:0]           idx;        // entry currently addressed
  logic                    phase;      // 0: read issued, 1: data present
  logic [TICK_WIDTH:0]     sum;        // running due time during scan
  logic [TICK_WIDTH-1:0]   carry;      // delay merged into successor
  logic [CW-1:0]           pos;        // insert slot
  logic                    pos_valid;  // insert slot was occupied
  logic [TICK_WIDTH-1:0]   pos_delay;
  logic [HANDLE_WIDTH-1:0] n_handle;
  logic [TICK_WIDTH-1:0]   n_delay, n_period;
  logic [15:0]             n_target;
  logic                    reinsert;
  logic [ID_WIDTH-1:0]     last_id;
  logic                    last_full;

  // shared adder
  logic [TICK_WIDTH:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic [ID_WIDTH-1:0] id_inc, id_new;
  assign id_inc = last_id + 1'b1;
  assign id_new = (id_inc == '0) ? ID_WIDTH'(1) : id_inc;

  // saturate a 16 bit input to TICK_WIDTH
  function automatic logic [TICK_WIDTH-1:0] sat16(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (TICK_WIDTH < 16 && (w >> TICK_WIDTH) != 0) begin
      return '1;
    end
    return TICK_WIDTH'(w);
  endfunction

  dlts_table #(
    .MAX_TASKS(MAX_TASKS), .TICK_WIDTH(TICK_WIDTH),
    .ID_WIDTH(ID_WIDTH), .HANDLE_WIDTH(HANDLE_WIDTH)
  ) u_table (
    .clk, .rst, .rd_addr, .rd_valid, .rd_handle, .rd_delay, .rd_period, .rd_id,
    .wr_en, .wr_addr, .wr_valid, .wr_handle, .wr_delay, .wr_period, .wr_id
  );

  assign in_ready = (state == dlts_pkg::S_IDLE);
  assign out_valid = (state == dlts_pkg::S_OUT);

  // shared adder operand select
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      dlts_pkg::S_FIND: begin
        add_a = sum;
        add_b = {1'b0, rd_delay};
      end
      dlts_pkg::S_REMOVE: begin
        add_a = {1'b0, rd_delay};
        add_b = {1'b0, carry};
      end
      dlts_pkg::S_PLACE: begin
        add_a = {1'b0, n_delay};
        add_b = ~sum + 1'b1;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  // table address / write
  always_comb begin
    rd_addr   = idx[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx[AW-1:0];
    wr_valid  = rd_valid;
    wr_handle = rd_handle;
    wr_delay  = rd_delay;
    wr_period = rd_period;
    wr_id     = rd_id;
    case (state)
      dlts_pkg::S_HEAD: begin
        if (phase && op == dlts_pkg::OP_TICK && rd_valid && rd_delay != '0) begin
          wr_en    = 1'b1;
          wr_delay = rd_delay - 1'b1;
        end
      end
      dlts_pkg::S_REMOVE: begin
        // idx = entry being filled; read came from idx+1
        if (phase) begin
          wr_en = 1'b1;
          if (idx == LAST) begin
            wr_valid = 1'b0;
          end
          if (carry != '0 || idx != pos) begin
            wr_delay = rd_delay;
          end
          if (idx == pos && rd_valid) begin
            wr_delay = add_y[TICK_WIDTH] ? TMAX : add_y[TICK_WIDTH-1:0];
          end
        end
        rd_addr = (idx == LAST) ? idx[AW-1:0] : AW'(idx + 1'b1);
      end
      dlts_pkg::S_SHIFT: begin
        // idx = destination; read from idx-1
        rd_addr = AW'(idx - 1'b1);
        if (phase) begin
          wr_en = 1'b1;
          if (idx == pos + 1'b1) begin
            wr_delay = pos_delay;
          end
        end
      end
      dlts_pkg::S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = pos[AW-1:0];
        wr_valid  = 1'b1;
        wr_handle = n_handle;
        wr_delay  = add_y[TICK_WIDTH-1:0];
        wr_period = n_period;
        wr_id     = id_new;
        if (!pos_valid) begin
          wr_delay = add_y[TICK_WIDTH-1:0];
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlts_pkg::S_IDLE;
      last_id   <= '0;
      idx       <= '0;
      phase     <= 1'b0;
      reinsert  <= 1'b0;
      last_full <= 1'b0;
    end else begin
      case (state)
        dlts_pkg::S_IDLE: begin
          if (in_valid) begin
            op          <= mode;
            n_handle    <= HANDLE_WIDTH'(task_handle);
            n_delay     <= sat16(start_delay);
            n_period    <= sat16(repeat_period);
            n_target    <= target_id;
            status      <= dlts_pkg::ST_DONE;
            assigned_id <= '0;
            ran_handle  <= '0;
            ran_id      <= '0;
            sum         <= '0;
            phase       <= 1'b0;
            reinsert    <= 1'b0;
            case (mode)
              dlts_pkg::OP_ADD: begin
                idx   <= LAST;   // probe last slot for full
                state <= dlts_pkg::S_FIND;
                last_full <= 1'b1;
              end
              dlts_pkg::OP_DELETE: begin
                idx   <= '0;
                state <= dlts_pkg::S_FIND;
              end
              default: begin
                idx   <= '0;
                state <= dlts_pkg::S_HEAD;
              end
            endcase
          end
        end
        dlts_pkg::S_HEAD: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (op == dlts_pkg::OP_TICK) begin
              state <= dlts_pkg::S_OUT;
            end else if (rd_valid && rd_delay == '0) begin
              ran_handle <= 8'(rd_handle);
              ran_id     <= 16'(rd_id);
              n_handle   <= rd_handle;
              n_delay    <= rd_period;
              n_period   <= rd_period;
              reinsert   <= (rd_period != '0);
              carry      <= rd_delay;
              pos        <= '0;
              idx        <= '0;
              state      <= dlts_pkg::S_REMOVE;
            end else begin
              status <= dlts_pkg::ST_NOTDUE;
              state  <= dlts_pkg::S_OUT;
            end
          end
        end
        dlts_pkg::S_FIND: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (last_full) begin
              // full-table probe for add
              last_full <= 1'b0;
              idx       <= '0;
              if (rd_valid) begin
                status <= dlts_pkg::ST_FULL;
                state  <= dlts_pkg::S_OUT;
              end
            end else if (op == dlts_pkg::OP_DELETE) begin
              if (n_target != '0 && rd_valid && 16'(rd_id) == n_target
                  && (ID_WIDTH >= 16 || (rd_id == ID_WIDTH'(n_target)))) begin
                carry <= rd_delay;
                pos   <= idx;
                state <= dlts_pkg::S_REMOVE;
              end else if (idx == LAST || !rd_valid) begin
                status <= dlts_pkg::ST_NOTFOUND;
                state  <= dlts_pkg::S_OUT;
              end else begin
                idx <= idx + 1'b1;
              end
            end else begin
              // insert scan: stop at first invalid or sum+delay > new delay
              if (!rd_valid || add_y > {1'b0, n_delay}) begin
                pos       <= idx;
                pos_valid <= rd_valid;
                pos_delay <= TICK_WIDTH'(add_y - {1'b0, n_delay});
                if (rd_valid) begin
                  idx   <= LAST;
                  state <= dlts_pkg::S_SHIFT;
                end else begin
                  state <= dlts_pkg::S_PLACE;
                end
              end else begin
                sum <= add_y;
                idx <= idx + 1'b1;
              end
            end
          end
        end
        dlts_pkg::S_REMOVE: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (idx == LAST) begin
              if (reinsert) begin
                sum       <= '0;
                idx       <= '0;
                state     <= dlts_pkg::S_FIND;
              end else begin
                state <= dlts_pkg::S_OUT;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        dlts_pkg::S_SHIFT: begin
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (idx == pos + 1'b1) begin
              state <= dlts_pkg::S_PLACE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        dlts_pkg::S_PLACE: begin
          last_id     <= id_new;
          assigned_id <= 16'(id_new);
          state       <= dlts_pkg::S_OUT;
        end
        dlts_pkg::S_OUT: begin
          if (out_ready) begin
            state <= dlts_pkg::S_IDLE;
          end
        end
        default: begin
          state <= dlts_pkg::S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == dlts_pkg::S_PLACE |-> id_new != '0) else $error("zero id");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for delta_list_task_scheduler
// Drives tick/add/delete/dispatch beats with bursty input and a stalling
// output, predicts each result from a delta-list model kept here, and
// compares every field of every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT    = 16;
  localparam int TICK_TOP = 65535;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  hnd;
    logic [15:0] dly;
    logic [15:0] per;
    logic [15:0] tid;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] aid;
    logic [7:0]  rh;
    logic [15:0] rid;
  } sched_res_t;

  // directed row: command plus optional typed-in result
  typedef struct packed {
    sched_cmd_t cmd;
    logic       fixed;
    sched_res_t res;
  } dir_row_t;

  typedef struct {
    bit          vld;
    logic [7:0]  hnd;
    int unsigned dly;
    int unsigned per;
    logic [15:0] id;
  } slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] mode = dlts_pkg::OP_TICK;
  logic [7:0] task_handle = '0;
  logic [15:0] start_delay = '0, repeat_period = '0, target_id = '0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] status;
  logic [15:0] assigned_id, ran_id;
  logic [7:0] ran_handle;

  slot_t       sched_tbl[NSLOT];
  logic [15:0] id_ctr;
  sched_res_t  due_results[$];
  logic [15:0] live_ids[$];
  int          mismatches = 0, res_seen = 0, items_sent = 0;
  bit          long_hold = 1'b0;

  delta_list_task_scheduler dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[delta_list_task_scheduler] ERROR");
    $finish;
  end

  function automatic logic [15:0] take_id();
    id_ctr = id_ctr + 16'd1;
    if (id_ctr == 16'd0) id_ctr = 16'd1;
    return id_ctr;
  endfunction

  function automatic logic [15:0] place_task(logic [7:0] h, int unsigned d, int unsigned p);
    longint unsigned acc;
    int pos;
    acc = 0;
    for (pos = 0; pos < NSLOT; pos++) begin
      if (!sched_tbl[pos].vld || acc + sched_tbl[pos].dly > d) break;
      acc += sched_tbl[pos].dly;
    end
    if (pos >= NSLOT) return 16'd0;
    if (sched_tbl[pos].vld) begin
      sched_tbl[pos].dly = int'(acc + sched_tbl[pos].dly - d);
      for (int k = NSLOT - 1; k > pos; k--) sched_tbl[k] = sched_tbl[k-1];
    end
    sched_tbl[pos].vld = 1'b1;
    sched_tbl[pos].hnd = h;
    sched_tbl[pos].dly = d - int'(acc);
    sched_tbl[pos].per = p;
    sched_tbl[pos].id  = take_id();
    return sched_tbl[pos].id;
  endfunction

  function automatic void drop_slot(int pos);
    longint unsigned m;
    if (pos + 1 < NSLOT && sched_tbl[pos+1].vld) begin
      m = longint'(sched_tbl[pos+1].dly) + sched_tbl[pos].dly;
      sched_tbl[pos+1].dly = (m > TICK_TOP) ? TICK_TOP : int'(m);
    end
    for (int k = pos; k < NSLOT - 1; k++) sched_tbl[k] = sched_tbl[k+1];
    sched_tbl[NSLOT-1] = '{default: 0};
  endfunction

  function automatic sched_res_t predict_sched(sched_cmd_t c);
    sched_res_t r;
    slot_t hd;
    r = '0;
    case (c.op)
      dlts_pkg::OP_TICK: if (sched_tbl[0].vld && sched_tbl[0].dly > 0) sched_tbl[0].dly--;
      dlts_pkg::OP_ADD: begin
        if (sched_tbl[NSLOT-1].vld) r.st = dlts_pkg::ST_FULL;
        else r.aid = place_task(c.hnd, c.dly, c.per);
      end
      dlts_pkg::OP_DELETE: begin
        r.st = dlts_pkg::ST_NOTFOUND;
        if (c.tid != 0)
          for (int i = 0; i < NSLOT; i++)
            if (sched_tbl[i].vld && sched_tbl[i].id == c.tid) begin
              drop_slot(i);
              r.st = dlts_pkg::ST_DONE;
              break;
            end
      end
      default: begin
        if (sched_tbl[0].vld && sched_tbl[0].dly == 0) begin
          hd = sched_tbl[0];
          r.rh = hd.hnd;
          r.rid = hd.id;
          drop_slot(0);
          if (hd.per != 0) r.aid = place_task(hd.hnd, hd.per, hd.per);
        end else r.st = dlts_pkg::ST_NOTDUE;
      end
    endcase
    return r;
  endfunction

  // pick a plausible live id from the model table
  function automatic logic [15:0] some_live_id();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) if (sched_tbl[i].vld) n++;
    if (n == 0) return 16'($urandom);
    return sched_tbl[$urandom_range(n-1)].id;
  endfunction

  // send one beat, hold until accepted; valid stays high for a following beat
  task automatic send_beat(sched_cmd_t c, bit fixed, sched_res_t want);
    sched_res_t p;
    p = predict_sched(c);
    if (fixed && p != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with prediction: row %h pred %h", want, p);
    end
    due_results.push_back(fixed ? want : p);
    mode <= c.op; task_handle <= c.hnd; start_delay <= c.dly;
    repeat_period <= c.per; target_id <= c.tid;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // idle the input; n sets the pause length
  task automatic pause_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic sched_cmd_t mk(logic [1:0] o, logic [7:0] h, logic [15:0] d,
                                    logic [15:0] p, logic [15:0] t);
    sched_cmd_t c;
    c.op = o; c.hnd = h; c.dly = d; c.per = p; c.tid = t;
    return c;
  endfunction

  function automatic sched_res_t rs(logic [1:0] s, logic [15:0] a, logic [7:0] h,
                                    logic [15:0] i);
    sched_res_t r;
    r.st = s; r.aid = a; r.rh = h; r.rid = i;
    return r;
  endfunction

  // result checking at the rising edge
  always @(posedge clk) begin
    sched_res_t got, exp_r;
    if (!rst && out_valid && out_ready) begin
      got = rs(status, assigned_id, ran_handle, ran_id);
      res_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = due_results.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d aid=%0d rh=%0d rid=%0d got st=%0d aid=%0d rh=%0d rid=%0d",
                     exp_r.st, exp_r.aid, exp_r.rh, exp_r.rid,
                     got.st, got.aid, got.rh, got.rid);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      phase = (phase + 1) % 64;
      if (phase < 16) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(3) != 0);
      @(negedge clk);
    end
  end

  // stop sending and wait for every expected result
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (due_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    @(negedge clk);
  endtask

  initial begin
    dir_row_t rows[$];
    sched_cmd_t c;
    int burst, r;
    logic [1:0] op;
    bit held, drained;
    for (int i = 0; i < NSLOT; i++) sched_tbl[i] = '{default: 0};
    id_ctr = '0;
    held = 1'b0;
    drained = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows: empty-table cases, extremes, equal due times, full table
    rows.push_back('{mk(dlts_pkg::OP_DISPATCH, 0, 0, 0, 0), 1,
                     rs(dlts_pkg::ST_NOTDUE, 0, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_TICK, 0, 0, 0, 0), 1, rs(dlts_pkg::ST_DONE, 0, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_DELETE, 0, 0, 0, 0), 1,
                     rs(dlts_pkg::ST_NOTFOUND, 0, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_ADD, 8'hFF, 0, 0, 0), 1, rs(dlts_pkg::ST_DONE, 1, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_DISPATCH, 0, 0, 0, 0), 1,
                     rs(dlts_pkg::ST_DONE, 0, 8'hFF, 1)});
    rows.push_back('{mk(dlts_pkg::OP_ADD, 8'hA5, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                     rs(dlts_pkg::ST_DONE, 2, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_ADD, 8'h5A, 16'hFFFF, 0, 0), 1,
                     rs(dlts_pkg::ST_DONE, 3, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_ADD, 8'h01, 3, 2, 0), 0, '0});
    rows.push_back('{mk(dlts_pkg::OP_DELETE, 0, 0, 0, 16'd2), 1,
                     rs(dlts_pkg::ST_DONE, 0, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_DELETE, 0, 0, 0, 16'hFFFF), 1,
                     rs(dlts_pkg::ST_NOTFOUND, 0, 0, 0)});
    rows.push_back('{mk(dlts_pkg::OP_ADD, 8'h02, 3, 0, 0), 0, '0});
    for (int k = 0; k < 3; k++) rows.push_back('{mk(dlts_pkg::OP_TICK, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(dlts_pkg::OP_DISPATCH, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(dlts_pkg::OP_DISPATCH, 0, 0, 0, 0), 0, '0});
    for (int k = 0; k < 14; k++)
      rows.push_back('{mk(dlts_pkg::OP_ADD, 8'(k), 16'(k), 0, 0), 0, '0});
    rows.push_back('{mk(dlts_pkg::OP_ADD, 8'h77, 5, 5, 0), 1, rs(dlts_pkg::ST_FULL, 0, 0, 0)});
    foreach (rows[i]) send_beat(rows[i].cmd, rows[i].fixed, rows[i].res);
    drain();

    // random part: bursts, ops weighted toward the live table
    r = 0;
    while (r < 550) begin
      if (!held && r >= 200) begin
        long_hold = 1'b1;
        held = 1'b1;
      end
      if (!drained && r >= 350) begin
        drain();
        drained = 1'b1;
      end
      burst = $urandom_range(12, 1);
      for (int b = 0; b < burst; b++) begin
        op = 2'($urandom);
        c = mk(op, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(3) != 0) begin
          c.dly = 16'($urandom_range(20));
          c.per = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(20));
        end
        if (op == dlts_pkg::OP_DELETE && $urandom_range(3) != 0) c.tid = some_live_id();
        send_beat(c, 1'b0, '0);
        r++;
      end
      if ($urandom_range(1)) pause_in($urandom_range(30, 1));
    end
    drain();
    repeat (300) @(negedge clk);
    $display("covered %0d items, %0d result beats, ids up to %0d", items_sent, res_seen,
             id_ctr);
    if (mismatches == 0 && due_results.size() == 0)
      $display("[delta_list_task_scheduler] OK");
    else
      $display("[delta_list_task_scheduler] ERROR");
    $finish;
  end
endmodule
